@@ design/integer_matrix_multiply_macros.svh @@
// Assertion macros used by the asserting file integer_matrix_multiply.sv.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Check expr in the same cycle as cond.
`define IMM_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check expr in the cycle after cond.
`define IMM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ design/imm_pkg.sv @@
`default_nettype none

package imm_pkg;

    localparam int ELEM_IN_W = 32;
    localparam int PRODUCT_W = 64;
    localparam int IDX_W = 3;
    localparam int DIM_REG_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        ST_LOAD_A,
        ST_LOAD_B,
        ST_COMPUTE
    } imm_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS     = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_B_COLS     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } issue_t;

    typedef struct packed {
        logic idle;
    } mac_status_t;

endpackage

`default_nettype wire

@@ design/integer_matrix_multiply.sv @@
// Channel   Dir  Fields (lowest bit first)                         Request when
// cfg       in   cfg_index[1:0], cfg_data[3:0]                      cfg_valid & cfg_ready
// s (in)    in   s_tdata: element[31:0]                             s_tvalid & s_tready
// m (out)   out  m_tdata: product[63:0], out_row[2:0], out_col[2:0]; m_tvalid & m_tready
//                tlast: last
//
// Loading takes one element per cycle, m*n elements of A then n*p of B.
// Each result needs one RAM read pair per inner term, fed into a single
// multiply-accumulate pipeline of read, multiply and accumulate registers.
// A stalled output holds one result and one more waits behind it; the next dot
// product starts once that waiting slot is free.
// Reset clears control state; matrix RAM contents are not cleared.
`default_nettype none

`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply #(
    parameter int MAX_DIM = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::DIM_REG_W-1:0]   cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [imm_pkg::ELEM_IN_W-1:0]   s_tdata,   // element[31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [imm_pkg::M_TDATA_W-1:0]   m_tdata,   // product[63:0], out_row, out_col, pad
    output logic                            m_tlast
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W = imm_pkg::M_TDATA_W - imm_pkg::PRODUCT_W - 2 * imm_pkg::IDX_W;

    logic                          left_we;
    logic                          right_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             left_rd_addr;
    logic [ADDR_W-1:0]             right_rd_addr;
    logic [ELEM_WIDTH-1:0]         left_data;
    logic [ELEM_WIDTH-1:0]         right_data;
    imm_pkg::issue_t               issue;
    imm_pkg::mac_status_t          status;
    logic [imm_pkg::PRODUCT_W-1:0] product;
    logic [imm_pkg::IDX_W-1:0]     out_row;
    logic [imm_pkg::IDX_W-1:0]     out_col;

    assign cfg_ready = 1'b1;

    imm_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .left_we(left_we),
        .right_we(right_we),
        .wr_addr(wr_addr),
        .left_rd_addr(left_rd_addr),
        .right_rd_addr(right_rd_addr),
        .issue(issue),
        .status(status)
    );

    imm_ram #(
        .DEPTH(DEPTH),
        .WIDTH(ELEM_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_left_ram (
        .clk(clk),
        .wr_en(left_we),
        .wr_addr(wr_addr),
        .wr_data(s_tdata[ELEM_WIDTH-1:0]),
        .rd_addr(left_rd_addr),
        .rd_data(left_data)
    );

    imm_ram #(
        .DEPTH(DEPTH),
        .WIDTH(ELEM_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_right_ram (
        .clk(clk),
        .wr_en(right_we),
        .wr_addr(wr_addr),
        .wr_data(s_tdata[ELEM_WIDTH-1:0]),
        .rd_addr(right_rd_addr),
        .rd_data(right_data)
    );

    imm_mac #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_mac (
        .clk(clk),
        .rst_n(rst_n),
        .left_data(left_data),
        .right_data(right_data),
        .issue(issue),
        .status(status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .product(product),
        .out_row(out_row),
        .out_col(out_col),
        .last(m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_col, out_row, product};

    `IMM_ASSERT_NOW(a_start_when_idle, clk, rst_n, issue.valid && issue.first, status.idle, "dot product started while accumulator busy")
    `IMM_ASSERT_NOW(a_no_read_during_load, clk, rst_n, s_tready, !issue.valid, "RAM read issued while loading")
    `IMM_ASSERT_NEXT(a_reload_after_last, clk, rst_n, issue.valid && issue.last, s_tready, "no return to loading after final term")

endmodule

`default_nettype wire

@@ design/imm_ram.sv @@
`default_nettype none

module imm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/imm_ctrl.sv @@
`default_nettype none

module imm_ctrl #(
    parameter int MAX_DIM = 8,
    localparam int DEPTH = MAX_DIM * MAX_DIM,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::DIM_REG_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    output logic                           left_we,
    output logic                           right_we,
    output logic [ADDR_W-1:0]              wr_addr,
    output logic [ADDR_W-1:0]              left_rd_addr,
    output logic [ADDR_W-1:0]              right_rd_addr,
    output imm_pkg::issue_t                issue,
    input  imm_pkg::mac_status_t           status
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LC_W = $clog2(DEPTH + 1);
    localparam int MN_W = 2 * CNT_W;
    localparam int CLAMP_W = imm_pkg::DIM_REG_W + 1;
    localparam int DIM_RESET = (MAX_DIM < 8) ? MAX_DIM : 8;

    imm_pkg::imm_state_t state_reg, state_next;
    logic [CNT_W-1:0]  m_reg, m_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [LC_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [DIM_W-1:0]  i_reg, i_next;
    logic [DIM_W-1:0]  j_reg, j_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;

    logic [MN_W-1:0] size_mn;
    logic [MN_W-1:0] size_np;
    logic            load_done;
    logic            accept;
    logic            k_last;
    logic            j_last;
    logic            i_last;
    logic            issue_go;
    logic            cfg_known;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [imm_pkg::DIM_REG_W-1:0] v);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (v == '0)
            clamp_dim = CNT_W'(1);
        else if (w > CLAMP_W'(MAX_DIM))
            clamp_dim = CNT_W'(MAX_DIM);
        else
            clamp_dim = CNT_W'(v);
    endfunction

    assign size_mn = MN_W'(m_reg) * MN_W'(n_reg);
    assign size_np = MN_W'(n_reg) * MN_W'(p_reg);
    assign load_done = (MN_W'(load_cnt_reg) + MN_W'(1)) ==
                       ((state_reg == imm_pkg::ST_LOAD_A) ? size_mn : size_np);
    assign s_tready = (state_reg == imm_pkg::ST_LOAD_A) || (state_reg == imm_pkg::ST_LOAD_B);
    assign accept = s_tvalid && s_tready;
    assign k_last = (CNT_W'(k_reg) + CNT_W'(1)) == n_reg;
    assign j_last = (CNT_W'(j_reg) + CNT_W'(1)) == p_reg;
    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == m_reg;
    assign issue_go = (state_reg == imm_pkg::ST_COMPUTE) && ((k_reg != '0) || status.idle);

    assign left_we = accept && (state_reg == imm_pkg::ST_LOAD_A);
    assign right_we = accept && (state_reg == imm_pkg::ST_LOAD_B);
    assign wr_addr = ADDR_W'(load_cnt_reg);
    assign left_rd_addr = a_addr_reg;
    assign right_rd_addr = b_addr_reg;

    assign issue.valid = issue_go;
    assign issue.first = (k_reg == '0);
    assign issue.last_k = k_last;
    assign issue.last = k_last && j_last && i_last;
    assign issue.row = imm_pkg::IDX_W'(i_reg);
    assign issue.col = imm_pkg::IDX_W'(j_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imm_pkg::ST_LOAD_A;
            m_reg <= CNT_W'(DIM_RESET);
            n_reg <= CNT_W'(DIM_RESET);
            p_reg <= CNT_W'(DIM_RESET);
            load_cnt_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            row_base_reg <= '0;
            a_addr_reg <= '0;
            b_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg <= m_next;
            n_reg <= n_next;
            p_reg <= p_next;
            load_cnt_reg <= load_cnt_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            row_base_reg <= row_base_next;
            a_addr_reg <= a_addr_next;
            b_addr_reg <= b_addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg;
        n_next = n_reg;
        p_next = p_reg;
        load_cnt_next = load_cnt_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        row_base_next = row_base_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        cfg_known = 1'b0;

        unique case (state_reg)
            imm_pkg::ST_LOAD_A:
            begin
                if (accept)
                begin
                    if (load_done)
                    begin
                        load_cnt_next = '0;
                        state_next = imm_pkg::ST_LOAD_B;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + LC_W'(1);
                    end
                end
            end
            imm_pkg::ST_LOAD_B:
            begin
                if (accept)
                begin
                    if (load_done)
                    begin
                        load_cnt_next = '0;
                        state_next = imm_pkg::ST_COMPUTE;
                        i_next = '0;
                        j_next = '0;
                        k_next = '0;
                        row_base_next = '0;
                        a_addr_next = '0;
                        b_addr_next = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + LC_W'(1);
                    end
                end
            end
            imm_pkg::ST_COMPUTE:
            begin
                if (issue_go)
                begin
                    if (!k_last)
                    begin
                        k_next = k_reg + DIM_W'(1);
                        a_addr_next = a_addr_reg + ADDR_W'(1);
                        b_addr_next = b_addr_reg + ADDR_W'(p_reg);
                    end
                    else
                    begin
                        k_next = '0;
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + DIM_W'(1);
                            row_base_next = row_base_reg + ADDR_W'(n_reg);
                            a_addr_next = row_base_reg + ADDR_W'(n_reg);
                            b_addr_next = '0;
                            if (i_last)
                            begin
                                state_next = imm_pkg::ST_LOAD_A;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + DIM_W'(1);
                            a_addr_next = row_base_reg;
                            b_addr_next = ADDR_W'(j_reg) + ADDR_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = imm_pkg::ST_LOAD_A;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (imm_pkg::cfg_index_t'(cfg_index))
                imm_pkg::CFG_A_ROWS:
                begin
                    m_next = clamp_dim(cfg_data);
                    cfg_known = 1'b1;
                end
                imm_pkg::CFG_INNER_SIZE:
                begin
                    n_next = clamp_dim(cfg_data);
                    cfg_known = 1'b1;
                end
                imm_pkg::CFG_B_COLS:
                begin
                    p_next = clamp_dim(cfg_data);
                    cfg_known = 1'b1;
                end
                default:
                begin
                    cfg_known = 1'b0;
                end
            endcase
            // drop any partial load or computation and restart loading A
            if (cfg_known)
            begin
                state_next = imm_pkg::ST_LOAD_A;
                load_cnt_next = '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/imm_mac.sv @@
`default_nettype none

module imm_mac #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ELEM_WIDTH-1:0]            left_data,
    input  logic [ELEM_WIDTH-1:0]            right_data,
    input  imm_pkg::issue_t                  issue,
    output imm_pkg::mac_status_t             status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [imm_pkg::PRODUCT_W-1:0]    product,
    output logic [imm_pkg::IDX_W-1:0]        out_row,
    output logic [imm_pkg::IDX_W-1:0]        out_col,
    output logic                             last
);

    localparam int MUL_W = 2 * ELEM_WIDTH;

    imm_pkg::issue_t tag1_reg;
    imm_pkg::issue_t tag2_reg;
    imm_pkg::issue_t res_tag_reg;
    imm_pkg::issue_t out_tag_reg;
    logic [imm_pkg::PRODUCT_W-1:0] prod_reg;
    logic [imm_pkg::PRODUCT_W-1:0] acc_reg;
    logic [imm_pkg::PRODUCT_W-1:0] res_reg;
    logic [imm_pkg::PRODUCT_W-1:0] out_prod_reg;
    logic                          pend_reg;
    logic                          out_valid_reg;

    logic signed [MUL_W-1:0]       mul;
    logic [imm_pkg::PRODUCT_W-1:0] acc_sum;
    logic                          load_out;

    assign mul = $signed(left_data) * $signed(right_data);
    assign acc_sum = tag2_reg.first ? prod_reg : acc_reg + prod_reg;
    assign load_out = pend_reg && (!out_valid_reg || m_tready);
    assign status.idle = !pend_reg && !tag1_reg.valid && !tag2_reg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= issue;
            tag2_reg <= tag1_reg;
            if (tag2_reg.valid && tag2_reg.last_k)
            begin
                pend_reg <= 1'b1;
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag1_reg.valid)
        begin
            prod_reg <= imm_pkg::PRODUCT_W'(mul);
        end
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_sum;
            if (tag2_reg.last_k)
            begin
                res_reg <= acc_sum;
                res_tag_reg <= tag2_reg;
            end
        end
        if (load_out)
        begin
            out_prod_reg <= res_reg;
            out_tag_reg <= res_tag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign product = out_prod_reg;
    assign out_row = out_tag_reg.row;
    assign out_col = out_tag_reg.col;
    assign last = out_tag_reg.last;

endmodule

`default_nettype wire
